// ----- design/glzw_pkg.sv -----
// Shared types and constants for the GIF LZW code stream encoder.
// No dependencies; every other design file imports this package.
package glzw_pkg;

    // Default sizes of the string table
    localparam int HASH_SLOTS_DEF = 8192;
    localparam int MAX_CODES_DEF  = 4096;

    // LZW special codes and width limits
    localparam logic [11:0] CLEAR_CODE  = 12'd256;
    localparam logic [11:0] END_CODE    = 12'd257;
    localparam logic [12:0] FIRST_FREE  = 13'd258;
    localparam logic [3:0]  START_WIDTH = 4'd9;
    localparam logic [3:0]  TOP_WIDTH   = 4'd12;

    // Multiplicative hash constant
    localparam logic [31:0] HASH_MULT = 32'd2654435761;

    // Width of the table generation tag; tag zero means empty
    localparam int EPOCH_W = 4;

    typedef struct packed {
        logic [7:0] pixel_index;
        logic       last_pixel;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_out_word;

    typedef enum logic [1:0] {
        SEL_PREFIX,
        SEL_CLEAR,
        SEL_END
    } t_code_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic      load_item;
        logic      addr_hash;
        logic      rd;
        logic      addr_inc;
        logic      hit_take;
        logic      insert;
        logic      prefix_pix;
        logic      tbl_clear;
        logic      sweep_step;
        logic      push;
        t_code_sel push_sel;
        logic      drain;
        logic      final_part;
        logic      pad;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic item_last;
        logic slot_empty;
        logic slot_match;
        logic table_full;
        logic bytes_ready;
        logic held_nz;
        logic out_free;
        logic epoch_wrap;
        logic sweep_done;
    } t_dp_sts;

endpackage

// ----- design/gif_lzw_code_stream_encoder.sv -----
// Top level of the GIF LZW code stream encoder.
// Depends on glzw_pkg, glzw_ctrl and glzw_dp.
//
// Takes one 8-bit palette index per word and emits the LSB-first packed
// LZW code stream, one byte per output word, with last_byte on the final
// byte of each frame. One pixel at a time is in flight: a hit passes through
// the hash step (registered hash) and one read and compare per probe of the
// hashed table; a miss adds a code push and a drain of each full byte.
// After reset, and on every 15th table clear, a sweep clears the table's
// generation tags; no pixel is accepted during the sweep.
module gif_lzw_code_stream_encoder import glzw_pkg::*; #(
    parameter int HASH_SLOTS = HASH_SLOTS_DEF,
    parameter int MAX_CODES  = MAX_CODES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    glzw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    glzw_dp #(
        .HASH_SLOTS (HASH_SLOTS),
        .MAX_CODES  (MAX_CODES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

endmodule

// ----- design/glzw_dp.sv -----
// Datapath: string table memory, hash, prefix and width registers,
// bit packer and output register. Depends on glzw_pkg.
module glzw_dp import glzw_pkg::*; #(
    parameter int HASH_SLOTS = HASH_SLOTS_DEF,
    parameter int MAX_CODES  = MAX_CODES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in_word,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    output t_out_word o_out_word,
    input  logic      i_out_stall
);

    localparam int IDX_W = $clog2(HASH_SLOTS);
    localparam int MEM_W = EPOCH_W + 32;

    logic [7:0]         r_pix;
    logic               r_last;
    logic [11:0]        r_prefix;
    logic [3:0]         r_width;
    logic [12:0]        r_nfc;
    logic [EPOCH_W-1:0] r_epoch;
    logic [IDX_W-1:0]   r_addr;
    logic [IDX_W-1:0]   r_swp;
    logic [MEM_W-1:0]   r_rd;
    logic [23:0]        r_acc;
    logic [4:0]         r_held;
    logic               r_out_valid;
    t_out_word          r_out_word;

    logic [MEM_W-1:0]   r_mem [HASH_SLOTS];

    logic [19:0]        w_key;
    logic [51:0]        w_prod;
    logic [11:0]        w_code;
    logic [11:0]        w_mask;
    logic [23:0]        w_push_bits;
    logic [12:0]        n_nfc;
    logic               w_out_free;

    assign w_key  = {r_prefix, r_pix};
    assign w_prod = 52'(w_key) * 52'(HASH_MULT);
    assign n_nfc  = r_nfc + 13'd1;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Code to pack, masked to the current width
    always_comb begin
        case (i_cmd.push_sel)
            SEL_PREFIX: w_code = r_prefix;
            SEL_CLEAR:  w_code = CLEAR_CODE;
            SEL_END:    w_code = END_CODE;
            default:    w_code = r_prefix;
        endcase
        w_mask      = ~(12'hFFF << r_width);
        w_push_bits = {12'd0, w_code & w_mask} << r_held;
    end

    // Item capture, registered table read and output word (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_pix  <= i_in_word.pixel_index;
            r_last <= i_in_word.last_pixel;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[r_addr];
        end
        if (i_cmd.drain || i_cmd.pad) begin
            r_out_word.out_byte  <= r_acc[7:0];
            r_out_word.last_byte <= i_cmd.pad || (i_cmd.final_part && r_held == 5'd8);
        end
    end

    // Table memory: inserts and the clearing sweep share the write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            r_mem[r_addr] <= {r_epoch, w_key, r_nfc[11:0]};
        end else if (i_cmd.sweep_step) begin
            r_mem[r_swp] <= '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix    <= '0;
            r_width     <= START_WIDTH;
            r_nfc       <= FIRST_FREE;
            r_epoch     <= EPOCH_W'(1);
            r_addr      <= '0;
            r_swp       <= '0;
            r_acc       <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // probe address: hash product registered, then linear steps
            if (i_cmd.addr_hash) begin
                r_addr <= w_prod[IDX_W-1:0];
            end else if (i_cmd.addr_inc) begin
                r_addr <= r_addr + IDX_W'(1);
            end
            if (i_cmd.sweep_step) begin
                r_swp <= r_swp + IDX_W'(1);
            end

            // prefix
            if (i_cmd.hit_take) begin
                r_prefix <= r_rd[11:0];
            end else if (i_cmd.prefix_pix) begin
                r_prefix <= {4'd0, r_pix};
            end

            // table fill, width growth one code late, and clear
            if (i_cmd.tbl_clear) begin
                r_width <= START_WIDTH;
                r_nfc   <= FIRST_FREE;
                r_epoch <= (r_epoch == '1) ? EPOCH_W'(1) : r_epoch + EPOCH_W'(1);
            end else if (i_cmd.insert) begin
                r_nfc <= n_nfc;
                if (r_width < TOP_WIDTH && n_nfc > (13'd1 << r_width)) begin
                    r_width <= r_width + 4'd1;
                end
            end

            // bit packer, LSB first
            if (i_cmd.push) begin
                r_acc  <= r_acc | w_push_bits;
                r_held <= r_held + 5'(r_width);
            end else if (i_cmd.drain) begin
                r_acc  <= r_acc >> 8;
                r_held <= r_held - 5'd8;
            end else if (i_cmd.pad) begin
                r_acc  <= '0;
                r_held <= '0;
            end

            // output register
            if (i_cmd.drain || i_cmd.pad) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.item_last   = r_last;
        o_sts.slot_empty  = r_rd[MEM_W-1 -: EPOCH_W] != r_epoch;
        o_sts.slot_match  = r_rd[31:12] == w_key;
        o_sts.table_full  = r_nfc == 13'(MAX_CODES);
        o_sts.bytes_ready = r_held >= 5'd8;
        o_sts.held_nz     = r_held != 5'd0;
        o_sts.out_free    = w_out_free;
        o_sts.epoch_wrap  = r_epoch == '1;
        o_sts.sweep_done  = r_swp == '1;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ----- design/glzw_ctrl.sv -----
// Controller: sequences lookup, probing, code emission and table clears.
// Depends on glzw_pkg; drives glzw_dp through command and status structs.
module glzw_ctrl import glzw_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_SWEEP, S_IDLE, S_FIRST_CLR, S_FIRST_PUSH, S_HASH, S_READ, S_CMP,
        S_MISS_PUSH, S_DRAIN, S_INSERT, S_FULL_PUSH, S_CLR_TBL, S_TAIL,
        S_LAST_PUSH, S_END_PUSH, S_PAD
    } t_state;

    // what follows once the packer has drained
    typedef enum logic [2:0] {
        AFT_INSERT, AFT_FULLCLR, AFT_CLEARTBL, AFT_TAIL, AFT_END, AFT_DONE
    } t_after;

    t_state r_state, n_state;
    t_after r_after, n_after;
    logic   r_in_frame, n_in_frame;
    logic   r_wrap, n_wrap;
    logic   r_boot, n_boot;

    always_comb begin
        n_state    = r_state;
        n_after    = r_after;
        n_in_frame = r_in_frame;
        n_wrap     = r_wrap;
        n_boot     = r_boot;
        o_cmd      = '0;
        o_cmd.push_sel   = SEL_PREFIX;
        o_cmd.final_part = r_after == AFT_DONE;

        unique case (r_state)
            S_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_done) begin
                    n_state = r_boot ? S_IDLE : S_TAIL;
                    n_boot  = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = r_in_frame ? S_HASH : S_FIRST_CLR;
                end
            end
            S_FIRST_CLR: begin
                o_cmd.tbl_clear = 1'b1;
                n_wrap  = i_sts.epoch_wrap;
                n_state = S_FIRST_PUSH;
            end
            S_FIRST_PUSH: begin
                o_cmd.push       = 1'b1;
                o_cmd.push_sel   = SEL_CLEAR;
                o_cmd.prefix_pix = 1'b1;
                n_in_frame = 1'b1;
                n_after    = AFT_TAIL;
                n_state    = S_DRAIN;
            end
            S_HASH: begin
                o_cmd.addr_hash = 1'b1;
                n_state = S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_sts.slot_empty) begin
                    n_state = S_MISS_PUSH;
                end else if (i_sts.slot_match) begin
                    o_cmd.hit_take = 1'b1;
                    n_state = S_TAIL;
                end else begin
                    o_cmd.addr_inc = 1'b1;
                    n_state = S_READ;
                end
            end
            S_MISS_PUSH: begin
                o_cmd.push = 1'b1;
                n_after = i_sts.table_full ? AFT_FULLCLR : AFT_INSERT;
                n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (i_sts.bytes_ready) begin
                    o_cmd.drain = i_sts.out_free;
                end else begin
                    unique case (r_after)
                        AFT_INSERT:   n_state = S_INSERT;
                        AFT_FULLCLR:  n_state = S_FULL_PUSH;
                        AFT_CLEARTBL: n_state = S_CLR_TBL;
                        AFT_TAIL:     n_state = S_TAIL;
                        AFT_END:      n_state = S_END_PUSH;
                        AFT_DONE:     n_state = S_PAD;
                        default:      n_state = S_TAIL;
                    endcase
                end
            end
            S_INSERT: begin
                o_cmd.insert     = 1'b1;
                o_cmd.prefix_pix = 1'b1;
                n_state = S_TAIL;
            end
            S_FULL_PUSH: begin
                o_cmd.push     = 1'b1;
                o_cmd.push_sel = SEL_CLEAR;
                n_after = AFT_CLEARTBL;
                n_state = S_DRAIN;
            end
            S_CLR_TBL: begin
                o_cmd.tbl_clear  = 1'b1;
                o_cmd.prefix_pix = 1'b1;
                n_wrap  = i_sts.epoch_wrap;
                n_state = S_TAIL;
            end
            S_TAIL: begin
                if (r_wrap) begin
                    n_wrap  = 1'b0;
                    n_state = S_SWEEP;
                end else if (i_sts.item_last) begin
                    n_state = S_LAST_PUSH;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_LAST_PUSH: begin
                o_cmd.push = 1'b1;
                n_after = AFT_END;
                n_state = S_DRAIN;
            end
            S_END_PUSH: begin
                o_cmd.push     = 1'b1;
                o_cmd.push_sel = SEL_END;
                n_after = AFT_DONE;
                n_state = S_DRAIN;
            end
            S_PAD: begin
                if (!i_sts.held_nz) begin
                    n_in_frame = 1'b0;
                    n_state    = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.pad  = 1'b1;
                    n_in_frame = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_SWEEP;
            r_after    <= AFT_TAIL;
            r_in_frame <= 1'b0;
            r_wrap     <= 1'b0;
            r_boot     <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_after    <= n_after;
            r_in_frame <= n_in_frame;
            r_wrap     <= n_wrap;
            r_boot     <= n_boot;
        end
    end

    assign o_in_stall = r_state != S_IDLE;

endmodule

// ----- design/glzw_checker.sv -----
// Port-level checks for the GIF LZW encoder, bound to the top level.
// Depends on glzw_pkg.
module glzw_checker import glzw_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed under stall");

    // a stalled input word holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_word))
        else $error("input word changed under stall");

    // one pixel at a time: busy right after a word is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while previous pixel in work");

    // the word after a frame's final byte never closes a frame
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out_word.last_byte
        |=> !(o_out_valid && o_out_word.last_byte))
        else $error("frame end right after frame end");

endmodule

bind gif_lzw_code_stream_encoder glzw_checker u_glzw_checker (.*);

// ----- dv/tb_top.sv -----
// Testbench for gif_lzw_code_stream_encoder: drives pixel words, predicts the
// packed LZW byte stream with its own hashed string table, checks each byte.
// Depends on glzw_pkg and the encoder RTL.
module tb_top;
    import glzw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS     = 8192;
    localparam int NCODES    = 4096;
    localparam int IDLE_PCT  = 9;
    localparam int WDOG_MAX  = 200000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out_word;

    gif_lzw_code_stream_encoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // Predictor state
    logic [19:0] tbl_key   [SLOTS];
    logic [11:0] tbl_code  [SLOTS];
    bit          tbl_used  [SLOTS];
    logic [11:0] pfx;
    logic [3:0]  cwidth;
    logic [12:0] free_code;
    logic [23:0] acc;
    logic [4:0]  nbits;
    bit          framing;

    t_in_word  pixel_q [$];
    t_out_word byte_q  [$];
    int  n_err;
    int  n_sent;
    int  hold_at;
    bit  quiet;
    bit  sending_done;
    bit  drain_hold;

    task automatic reset_table();
        foreach (tbl_used[i]) tbl_used[i] = 0;
        cwidth    = START_WIDTH;
        free_code = FIRST_FREE;
    endtask

    // Pack one code LSB first, queueing each complete byte
    task automatic pack_code(input logic [11:0] code);
        int w;
        t_out_word b;
        w = cwidth;
        acc = acc | (24'(code & ((12'd1 << w) - 1)) << nbits);
        nbits = nbits + w;
        while (nbits >= 8) begin
            b.out_byte  = acc[7:0];
            b.last_byte = 1'b0;
            byte_q.push_back(b);
            acc   = acc >> 8;
            nbits = nbits - 8;
        end
    endtask

    // Compute the bytes that one accepted pixel word produces
    task automatic predict_pixel(input t_in_word wd);
        logic [19:0] key;
        logic [31:0] h;
        int slot;
        bit hit;
        int q_start;
        t_out_word b;
        q_start = byte_q.size();
        if (!framing) begin
            reset_table();
            pack_code(CLEAR_CODE);
            pfx = 12'(wd.pixel_index);
            framing = 1;
        end else begin
            key = {pfx, wd.pixel_index};
            h = 32'(key) * HASH_MULT;
            slot = h % SLOTS;
            hit = 0;
            while (tbl_used[slot]) begin
                if (tbl_key[slot] == key) begin
                    hit = 1;
                    break;
                end
                slot = (slot + 1) % SLOTS;
            end
            if (hit) begin
                pfx = tbl_code[slot];
            end else begin
                pack_code(pfx);
                if (free_code < NCODES) begin
                    tbl_key[slot]  = key;
                    tbl_code[slot] = free_code[11:0];
                    tbl_used[slot] = 1;
                    free_code++;
                    if (cwidth < TOP_WIDTH && free_code > (13'd1 << cwidth))
                        cwidth++;
                end else begin
                    pack_code(CLEAR_CODE);
                    reset_table();
                end
                pfx = 12'(wd.pixel_index);
            end
        end
        if (wd.last_pixel) begin
            pack_code(pfx);
            pack_code(END_CODE);
            if (nbits > 0) begin
                b.out_byte  = acc[7:0];
                b.last_byte = 1'b0;
                byte_q.push_back(b);
            end
            acc   = '0;
            nbits = '0;
            if (byte_q.size() > q_start) byte_q[$].last_byte = 1'b1;
            framing = 0;
        end
    endtask

    function automatic bit want_idle();
        return !quiet && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Clock
    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_pixel(i_in_word);
                n_sent = n_sent + 1;
            end
            if (i_in_valid && o_in_stall) begin
                // hold payload
            end else if (pixel_q.size() == 0 || want_idle()
                         || (n_sent + (i_in_valid && !o_in_stall ? 0 : 0) == hold_at
                             && drain_hold)) begin
                i_in_valid <= 1'b0;
                if (pixel_q.size() == 0) sending_done <= 1'b1;
            end else begin
                i_in_valid <= 1'b1;
                i_in_word  <= pixel_q.pop_front();
            end
        end
    end

    // Pause the sender once until every expected byte has come
    always @(posedge i_clk) begin
        if (i_rst_n && n_sent == hold_at && !i_in_valid)
            drain_hold <= byte_q.size() != 0 || !drain_hold ? byte_q.size() != 0 : 1'b0;
    end

    // Monitor and output stall
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (byte_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("unexpected byte %h last %b",
                                 o_out_word.out_byte, o_out_word.last_byte);
                end else begin
                    exp_w = byte_q.pop_front();
                    if (exp_w.out_byte !== o_out_word.out_byte
                        || exp_w.last_byte !== o_out_word.last_byte) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("byte mismatch: exp %h/%b got %h/%b",
                                     exp_w.out_byte, exp_w.last_byte,
                                     o_out_word.out_byte, o_out_word.last_byte);
                    end
                end
            end
            i_out_stall <= want_idle();
        end
    end

    // Queue one frame of pixels; runs favor repeats to exercise table hits
    task automatic add_frame(input int len, input int alpha);
        t_in_word wd;
        for (int i = 0; i < len; i++) begin
            wd.pixel_index = (alpha >= 256) ? 8'($urandom) : 8'($urandom_range(alpha - 1));
            wd.last_pixel  = (i == len - 1);
            pixel_q.push_back(wd);
        end
    endtask

    initial begin
        int idle_cnt;
        t_in_word wd;
        i_rst_n      = 0;
        i_in_valid   = 0;
        i_out_stall  = 0;
        i_in_word    = '0;
        n_err        = 0;
        n_sent       = 0;
        quiet        = 0;
        sending_done = 0;
        drain_hold   = 1;
        pfx = '0; acc = '0; nbits = '0; framing = 0;
        reset_table();

        // Directed: one-pixel frames at the index extremes and at 8'hA5, then small frames
        wd = '{8'h00, 1'b1}; pixel_q.push_back(wd);
        wd = '{8'hFF, 1'b1}; pixel_q.push_back(wd);
        wd = '{8'hA5, 1'b1}; pixel_q.push_back(wd);
        for (int i = 0; i < 8; i++) begin
            wd = '{8'h00, i == 7};
            pixel_q.push_back(wd);
        end
        wd = '{8'h5A, 1'b0}; pixel_q.push_back(wd);
        wd = '{8'hFF, 1'b0}; pixel_q.push_back(wd);
        wd = '{8'h5A, 1'b0}; pixel_q.push_back(wd);
        wd = '{8'hFF, 1'b1}; pixel_q.push_back(wd);
        hold_at = pixel_q.size();

        // Random frames, mostly small, and one longer frame of random indexes
        for (int f = 0; f < 12; f++)
            add_frame($urandom_range(1, 14), ($urandom_range(1) != 0) ? 256 : 4);
        add_frame(40, 256);
        for (int f = 0; f < 4; f++)
            add_frame($urandom_range(1, 10), 3);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Watchdog and quiet stretch in the middle of the run
        idle_cnt = 0;
        while (!(sending_done && pixel_q.size() == 0 && !i_in_valid
                 && byte_q.size() == 0)) begin
            @(posedge i_clk);
            quiet = (n_sent > 60 && n_sent < 120);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cnt = 0;
            else
                idle_cnt++;
            if (idle_cnt >= WDOG_MAX) begin
                $display("FAIL gif_lzw_code_stream_encoder");
                $finish;
            end
        end
        repeat (100) @(posedge i_clk);
        if (n_err == 0 && byte_q.size() == 0) begin
            $display("PASS gif_lzw_code_stream_encoder");
        end else begin
            $display("FAIL gif_lzw_code_stream_encoder");
        end
        $finish;
    end
endmodule
